// ----- hw/rtl/tssq_pkg.sv -----
package tssq_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_CURTAIN_TRAVEL = 3'd0;
   localparam logic [2:0] CSR_SETTLE_WAIT    = 3'd1;
   localparam logic [2:0] CSR_DEBOUNCE       = 3'd2;
   localparam logic [2:0] CSR_MOTOR_DUTY     = 3'd3;
   localparam logic [2:0] CSR_OCTAVE_OFFSET  = 3'd4;

   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 16;

   // configuration reset values
   localparam logic [15:0] CURTAIN_TRAVEL_RESET = 16'd3000;
   localparam logic [15:0] SETTLE_WAIT_RESET    = 16'd1000;
   localparam logic [7:0]  DEBOUNCE_RESET       = 8'd30;
   localparam logic [7:0]  MOTOR_DUTY_RESET     = 8'd120;
   localparam logic [7:0]  OCTAVE_OFFSET_RESET  = 8'd13;

   // motor direction codes
   localparam logic [1:0] MOTOR_STOP  = 2'd0;
   localparam logic [1:0] MOTOR_OPEN  = 2'd1;
   localparam logic [1:0] MOTOR_CLOSE = 2'd2;

   localparam logic [3:0] BARS_PER_SHOW  = 4'd12;
   localparam logic [7:0] DEFAULT_OFFSET = 8'd0;
   localparam int unsigned SINCE_BITS    = 9;

   // spotlight windows
   localparam logic [3:0] MAIN_ONE_LAST    = 4'd7;
   localparam logic [3:0] MAIN_TWO_FIRST   = 4'd2;
   localparam logic [3:0] MAIN_TWO_LAST    = 4'd9;
   localparam logic [3:0] MAIN_THREE_FIRST = 4'd4;

   typedef struct packed {
      logic [15:0] curtain_travel_ms;
      logic [15:0] settle_wait_ms;
      logic [7:0]  bounce_hold;
      logic [7:0]  motor_duty;
      logic [7:0]  octave_offset;
   } tssq_cfg_type;

   typedef struct packed {
      logic [2:0] stage;
      logic [1:0] motor_direction;
      logic [7:0] motor_pwm;
      logic [3:0] lights;        // bit0 main one .. bit2 main three, bit3 rhythm
      logic       bar_valid;
      logic [7:0] bar_number;
   } tssq_result_type;

   function automatic logic [3:0] lights_for(input logic [3:0] step);
      logic [3:0] b;
      b    = 4'b1000;
      b[0] = (step <= MAIN_ONE_LAST);
      b[1] = (step >= MAIN_TWO_FIRST) && (step <= MAIN_TWO_LAST);
      b[2] = (step >= MAIN_THREE_FIRST);
      return b;
   endfunction

endpackage

// ----- hw/rtl/tssq_debounce.sv -----
module tssq_debounce
   import tssq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       tick,
   input  logic       sample,
   input  logic       level,
   input  logic [7:0] bounce_hold,
   output logic       rise
);

   logic                  last_ff, last_in;
   logic                  stable_ff, stable_in;
   logic [SINCE_BITS-1:0] since_ff, since_in;
   logic [SINCE_BITS-1:0] since_inc;

   always_comb begin
      since_inc = (since_ff == {SINCE_BITS{1'b1}}) ? since_ff : since_ff + 1'b1;
      since_in  = since_inc;
      last_in   = last_ff;
      stable_in = stable_ff;
      rise      = 1'b0;
      if (sample) begin
         if (level != last_ff) begin
            since_in = '0;
            last_in  = level;
         end
         if ((since_in > SINCE_BITS'(bounce_hold)) && (level != stable_ff)) begin
            stable_in = level;
            rise      = level;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff   <= 1'b0;
         stable_ff <= 1'b0;
         since_ff  <= '0;
      end else if (tick) begin
         last_ff   <= last_in;
         stable_ff <= stable_in;
         since_ff  <= since_in;
      end
   end

endmodule

// ----- hw/rtl/tssq_core.sv -----
module tssq_core
   import tssq_pkg::*;
#(
   parameter int unsigned TIMER_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            tick,
   input  logic            level_default,
   input  logic            level_octave,
   input  logic [15:0]     bar_interval_ms,
   input  tssq_cfg_type    cfg,
   output tssq_result_type result
);

   localparam int unsigned CMP_BITS = (TIMER_BITS > 16) ? TIMER_BITS : 16;

   typedef enum logic [2:0] {
      ST_WAIT   = 3'd0,
      ST_OPEN   = 3'd1,
      ST_BEFORE = 3'd2,
      ST_PLAY   = 3'd3,
      ST_AFTER  = 3'd4,
      ST_CLOSE  = 3'd5
   } stage_type;

   stage_type             stage_ff, stage_in;
   logic                  octave_ff, octave_in;
   logic [3:0]            step_ff, step_in;
   logic [TIMER_BITS-1:0] phase_ff, phase_in;
   logic [TIMER_BITS-1:0] bar_ff, bar_in;
   logic [1:0]            motor_ff, motor_in;
   logic [3:0]            light_ff, light_in;

   logic [TIMER_BITS-1:0] phase_tick, bar_tick;
   logic [3:0]            step_inc;
   logic                  bar_out;
   logic                  wait_stage;
   logic                  go_default, go_octave;
   logic [7:0]            offset;

   function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
      return (v == {TIMER_BITS{1'b1}}) ? v : v + 1'b1;
   endfunction

   // threshold beyond the counter range compares as the counter maximum
   function automatic logic reached(input logic [TIMER_BITS-1:0] elapsed,
                                    input logic [15:0] thr);
      logic [CMP_BITS-1:0] e, t, m;
      e = CMP_BITS'(elapsed);
      t = CMP_BITS'(thr);
      m = CMP_BITS'({TIMER_BITS{1'b1}});
      if (t > m) t = m;
      return e >= t;
   endfunction

   assign wait_stage = !((stage_ff == ST_OPEN)  || (stage_ff == ST_BEFORE) ||
                         (stage_ff == ST_PLAY)  || (stage_ff == ST_AFTER)  ||
                         (stage_ff == ST_CLOSE));

   tssq_debounce u_db_default (
      .clock       (clock),
      .reset       (reset),
      .tick        (tick),
      .sample      (wait_stage),
      .level       (level_default),
      .bounce_hold (cfg.bounce_hold),
      .rise        (go_default)
   );

   tssq_debounce u_db_octave (
      .clock       (clock),
      .reset       (reset),
      .tick        (tick),
      .sample      (wait_stage),
      .level       (level_octave),
      .bounce_hold (cfg.bounce_hold),
      .rise        (go_octave)
   );

   always_comb begin
      phase_tick = sat_inc(phase_ff);
      bar_tick   = sat_inc(bar_ff);
      step_inc   = step_ff + 4'd1;
      stage_in   = stage_ff;
      octave_in  = octave_ff;
      step_in    = step_ff;
      phase_in   = phase_tick;
      bar_in     = bar_tick;
      motor_in   = motor_ff;
      light_in   = light_ff;
      bar_out    = 1'b0;
      case (stage_ff)
         ST_OPEN: begin
            if (reached(phase_tick, cfg.curtain_travel_ms)) begin
               motor_in = MOTOR_STOP;
               phase_in = '0;
               stage_in = ST_BEFORE;
            end
         end
         ST_BEFORE: begin
            if (reached(phase_tick, cfg.settle_wait_ms)) begin
               step_in  = '0;
               bar_out  = 1'b1;
               light_in = lights_for(4'd0);
               bar_in   = '0;
               stage_in = ST_PLAY;
            end
         end
         ST_PLAY: begin
            if (reached(bar_tick, bar_interval_ms)) begin
               bar_in  = '0;
               step_in = step_inc;
               if (step_inc < BARS_PER_SHOW) begin
                  bar_out  = 1'b1;
                  light_in = lights_for(step_inc);
               end else begin
                  light_in = '0;
                  phase_in = '0;
                  stage_in = ST_AFTER;
               end
            end
         end
         ST_AFTER: begin
            if (reached(phase_tick, cfg.settle_wait_ms)) begin
               motor_in = MOTOR_CLOSE;
               phase_in = '0;
               stage_in = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            if (reached(phase_tick, cfg.curtain_travel_ms)) begin
               motor_in = MOTOR_STOP;
               stage_in = ST_WAIT;
            end
         end
         default: begin
            stage_in = ST_WAIT;
            // octave wins on a simultaneous rise
            if (go_default || go_octave) begin
               octave_in = go_octave;
               motor_in  = MOTOR_OPEN;
               phase_in  = '0;
               stage_in  = ST_OPEN;
            end
         end
      endcase
   end

   assign offset = octave_ff ? cfg.octave_offset : DEFAULT_OFFSET;

   always_comb begin
      result.stage           = stage_in;
      result.motor_direction = motor_in;
      result.motor_pwm       = (motor_in != MOTOR_STOP) ? cfg.motor_duty : 8'd0;
      result.lights          = light_in;
      result.bar_valid       = bar_out;
      result.bar_number      = bar_out ? offset + {4'd0, step_in} : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff  <= ST_WAIT;
         octave_ff <= 1'b0;
         step_ff   <= '0;
         phase_ff  <= '0;
         bar_ff    <= '0;
         motor_ff  <= MOTOR_STOP;
         light_ff  <= '0;
      end else if (tick) begin
         stage_ff  <= stage_in;
         octave_ff <= octave_in;
         step_ff   <= step_in;
         phase_ff  <= phase_in;
         bar_ff    <= bar_in;
         motor_ff  <= motor_in;
         light_ff  <= light_in;
      end
   end

   a_bar_in_play: assert property (@(posedge clock) disable iff (reset)
      tick && bar_out |=> stage_ff == ST_PLAY)
      else $error("bar issued outside play");

   a_motor_open: assert property (@(posedge clock) disable iff (reset)
      (motor_ff == MOTOR_OPEN) == (stage_ff == ST_OPEN))
      else $error("opening leg out of step with stage");

   a_motor_close: assert property (@(posedge clock) disable iff (reset)
      (motor_ff == MOTOR_CLOSE) == (stage_ff == ST_CLOSE))
      else $error("closing leg out of step with stage");

   a_lights_play: assert property (@(posedge clock) disable iff (reset)
      (light_ff != 4'd0) |-> (stage_ff == ST_PLAY))
      else $error("spotlight on outside play");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= BARS_PER_SHOW)
      else $error("bar step overran");

endmodule

// ----- hw/rtl/tssq_skid.sv -----
module tssq_skid
   import tssq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  tssq_result_type push_data,
   output logic            push_ready,
   output logic            out_valid,
   input  logic            out_ready,
   output tssq_result_type out_data
);

   logic            out_valid_ff, out_valid_in;
   tssq_result_type out_data_ff, out_data_in;
   logic            skid_valid_ff, skid_valid_in;
   tssq_result_type skid_data_ff, skid_data_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            // push is held off while the skid entry is full
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign push_ready = !skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_data   = out_data_ff;

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

endmodule

// ----- hw/rtl/timed_stage_show_sequencer.sv -----
// The stage update is a single registered pass; each result is registered toward rsp_.
// Throughput: one tick item per clock while req_ready is high (skid entry empty).
// An output register plus one skid entry let req_ready stay high while a result waits.
// Reset (synchronous, active high): stage waiting for a button, motor stopped, lights off,
// all counters zero, configuration back to its defaults, no result pending.
module timed_stage_show_sequencer
   import tssq_pkg::*;
#(
   parameter int unsigned TIMER_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // tick items
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_button_default_level,
   input  logic                      req_button_octave_level,
   input  logic [15:0]               req_bar_interval_ms,
   // result items
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_stage,
   output logic [1:0]                rsp_motor_direction,
   output logic [7:0]                rsp_motor_pwm,
   output logic                      rsp_light_main_one,
   output logic                      rsp_light_main_two,
   output logic                      rsp_light_main_three,
   output logic                      rsp_light_rhythm,
   output logic                      rsp_bar_valid,
   output logic [7:0]                rsp_bar_number,
   // configuration writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   tssq_cfg_type    cfg_ff, cfg_in;
   tssq_result_type core_result;
   tssq_result_type rsp_data;
   logic            tick;

   // Config writes are always taken; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CURTAIN_TRAVEL: cfg_in.curtain_travel_ms = csr_wdata;
            CSR_SETTLE_WAIT:    cfg_in.settle_wait_ms    = csr_wdata;
            CSR_DEBOUNCE:       cfg_in.bounce_hold       = csr_wdata[7:0];
            CSR_MOTOR_DUTY:     cfg_in.motor_duty        = csr_wdata[7:0];
            CSR_OCTAVE_OFFSET:  cfg_in.octave_offset     = csr_wdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.curtain_travel_ms <= CURTAIN_TRAVEL_RESET;
         cfg_ff.settle_wait_ms    <= SETTLE_WAIT_RESET;
         cfg_ff.bounce_hold       <= DEBOUNCE_RESET;
         cfg_ff.motor_duty        <= MOTOR_DUTY_RESET;
         cfg_ff.octave_offset     <= OCTAVE_OFFSET_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // One accepted item is one millisecond tick.
   assign tick = req_valid && req_ready;

   // Stage sequencer: state registers plus the per-tick update logic.
   tssq_core #(
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .tick            (tick),
      .level_default   (req_button_default_level),
      .level_octave    (req_button_octave_level),
      .bar_interval_ms (req_bar_interval_ms),
      .cfg             (cfg_ff),
      .result          (core_result)
   );

   // Result register with a skid entry toward the rsp_ side.
   tssq_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push       (tick),
      .push_data  (core_result),
      .push_ready (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (rsp_data)
   );

   assign rsp_stage            = rsp_data.stage;
   assign rsp_motor_direction  = rsp_data.motor_direction;
   assign rsp_motor_pwm        = rsp_data.motor_pwm;
   assign rsp_light_main_one   = rsp_data.lights[0];
   assign rsp_light_main_two   = rsp_data.lights[1];
   assign rsp_light_main_three = rsp_data.lights[2];
   assign rsp_light_rhythm     = rsp_data.lights[3];
   assign rsp_bar_valid        = rsp_data.bar_valid;
   assign rsp_bar_number       = rsp_data.bar_number;

endmodule

// ----- test/tb_timed_stage_show_sequencer.sv -----
`timescale 1ns / 100ps

module tb_timed_stage_show_sequencer;
   import tssq_pkg::*;

   localparam int unsigned TIMER_BITS = 16;
   localparam longint unsigned TIMER_MAX = (64'd1 << TIMER_BITS) - 1;
   localparam int unsigned SINCE_CAP = (1 << SINCE_BITS) - 1;

   // show stages as reported on rsp_stage
   localparam logic [2:0] ST_WAIT_BUTTON = 3'd0;
   localparam logic [2:0] ST_OPENING     = 3'd1;
   localparam logic [2:0] ST_WAIT_BEFORE = 3'd2;
   localparam logic [2:0] ST_PLAYING     = 3'd3;
   localparam logic [2:0] ST_WAIT_AFTER  = 3'd4;
   localparam logic [2:0] ST_CLOSING     = 3'd5;

   // index past the register list; writes there must change nothing
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   // ------------------------------------------------------------------
   // Show tracker: mirrors the sequencer tick by tick and holds the
   // results still owed by the block.
   // ------------------------------------------------------------------
   class show_tracker;
      tssq_cfg_type    cfg;
      logic [2:0]      stage_now;
      logic            octave_sel;
      logic [3:0]      bar_step;
      logic [TIMER_BITS-1:0] phase_ms;
      logic [TIMER_BITS-1:0] bar_ms;
      logic            def_last, def_stable, oct_last, oct_stable;
      int unsigned     def_since, oct_since;
      logic [1:0]      motor;
      logic [3:0]      lights;
      tssq_result_type pending_results[$];
      int unsigned     errors;

      function new();
         cfg.curtain_travel_ms = CURTAIN_TRAVEL_RESET;
         cfg.settle_wait_ms    = SETTLE_WAIT_RESET;
         cfg.bounce_hold       = DEBOUNCE_RESET;
         cfg.motor_duty        = MOTOR_DUTY_RESET;
         cfg.octave_offset     = OCTAVE_OFFSET_RESET;
         stage_now  = ST_WAIT_BUTTON;
         octave_sel = 1'b0;
         bar_step   = '0;
         phase_ms   = '0;
         bar_ms     = '0;
         def_last   = 1'b0;
         def_stable = 1'b0;
         oct_last   = 1'b0;
         oct_stable = 1'b0;
         def_since  = 0;
         oct_since  = 0;
         motor      = MOTOR_STOP;
         lights     = '0;
         errors     = 0;
      endfunction

      function void write_reg(input logic [2:0] idx, input logic [15:0] data);
         case (idx)
            CSR_CURTAIN_TRAVEL: cfg.curtain_travel_ms = data;
            CSR_SETTLE_WAIT:    cfg.settle_wait_ms    = data;
            CSR_DEBOUNCE:       cfg.bounce_hold       = data[7:0];
            CSR_MOTOR_DUTY:     cfg.motor_duty        = data[7:0];
            CSR_OCTAVE_OFFSET:  cfg.octave_offset     = data[7:0];
            default: ;
         endcase
      endfunction

      function logic [TIMER_BITS-1:0] count_up(input logic [TIMER_BITS-1:0] v);
         return (v == TIMER_MAX) ? v : v + 1'b1;
      endfunction

      // thresholds wider than the timer compare as the timer's maximum
      function bit reached(input logic [TIMER_BITS-1:0] elapsed, input logic [15:0] thr);
         longint unsigned lim;
         lim = (thr > TIMER_MAX) ? TIMER_MAX : thr;
         return elapsed >= lim;
      endfunction

      function logic [3:0] spot_mask(input logic [3:0] step);
         logic [3:0] m;
         m = 4'b1000;
         if (step <= MAIN_ONE_LAST) m[0] = 1'b1;
         if (step >= MAIN_TWO_FIRST && step <= MAIN_TWO_LAST) m[1] = 1'b1;
         if (step >= MAIN_THREE_FIRST) m[2] = 1'b1;
         return m;
      endfunction

      // returns 1 on a debounced rise
      function bit debounce_rise(input logic lvl, inout logic last, inout logic stable,
                                 inout int unsigned since);
         if (lvl != last) begin
            since = 0;
            last  = lvl;
         end
         if (since > cfg.bounce_hold && lvl != stable) begin
            stable = lvl;
            return lvl;
         end
         return 1'b0;
      endfunction

      function void predict_tick(input logic lvl_def, input logic lvl_oct,
                                 input logic [15:0] interval);
         tssq_result_type r;
         bit bar_now, go_def, go_oct;
         logic [7:0] offs;
         bar_now  = 1'b0;
         phase_ms = count_up(phase_ms);
         bar_ms   = count_up(bar_ms);
         if (def_since < SINCE_CAP) def_since++;
         if (oct_since < SINCE_CAP) oct_since++;
         case (stage_now)
            ST_OPENING: begin
               if (reached(phase_ms, cfg.curtain_travel_ms)) begin
                  motor     = MOTOR_STOP;
                  phase_ms  = '0;
                  stage_now = ST_WAIT_BEFORE;
               end
            end
            ST_WAIT_BEFORE: begin
               if (reached(phase_ms, cfg.settle_wait_ms)) begin
                  bar_step  = '0;
                  bar_now   = 1'b1;
                  lights    = spot_mask(4'd0);
                  bar_ms    = '0;
                  stage_now = ST_PLAYING;
               end
            end
            ST_PLAYING: begin
               if (reached(bar_ms, interval)) begin
                  bar_ms   = '0;
                  bar_step = bar_step + 1'b1;
                  if (bar_step < BARS_PER_SHOW) begin
                     bar_now = 1'b1;
                     lights  = spot_mask(bar_step);
                  end else begin
                     lights    = '0;
                     phase_ms  = '0;
                     stage_now = ST_WAIT_AFTER;
                  end
               end
            end
            ST_WAIT_AFTER: begin
               if (reached(phase_ms, cfg.settle_wait_ms)) begin
                  motor     = MOTOR_CLOSE;
                  phase_ms  = '0;
                  stage_now = ST_CLOSING;
               end
            end
            ST_CLOSING: begin
               if (reached(phase_ms, cfg.curtain_travel_ms)) begin
                  motor     = MOTOR_STOP;
                  stage_now = ST_WAIT_BUTTON;
               end
            end
            default: begin
               go_def    = debounce_rise(lvl_def, def_last, def_stable, def_since);
               go_oct    = debounce_rise(lvl_oct, oct_last, oct_stable, oct_since);
               stage_now = ST_WAIT_BUTTON;
               if (go_def || go_oct) begin
                  octave_sel = go_oct;
                  motor      = MOTOR_OPEN;
                  phase_ms   = '0;
                  stage_now  = ST_OPENING;
               end
            end
         endcase
         offs                = octave_sel ? cfg.octave_offset : DEFAULT_OFFSET;
         r.stage             = stage_now;
         r.motor_direction   = motor;
         r.motor_pwm         = (motor != MOTOR_STOP) ? cfg.motor_duty : 8'd0;
         r.lights            = lights;
         r.bar_valid         = bar_now;
         r.bar_number        = bar_now ? offs + {4'd0, bar_step} : 8'd0;
         pending_results.push_back(r);
      endfunction

      function void cmp(input string field, input int unsigned want, input int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_result(input tssq_result_type got);
         tssq_result_type want;
         if (pending_results.size() == 0) begin
            $error("result item with nothing expected (stage %0d)", got.stage);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         cmp("stage", 32'(want.stage), 32'(got.stage));
         cmp("motor_direction", 32'(want.motor_direction), 32'(got.motor_direction));
         cmp("motor_pwm", 32'(want.motor_pwm), 32'(got.motor_pwm));
         cmp("light_main_one", 32'(want.lights[0]), 32'(got.lights[0]));
         cmp("light_main_two", 32'(want.lights[1]), 32'(got.lights[1]));
         cmp("light_main_three", 32'(want.lights[2]), 32'(got.lights[2]));
         cmp("light_rhythm", 32'(want.lights[3]), 32'(got.lights[3]));
         cmp("bar_valid", 32'(want.bar_valid), 32'(got.bar_valid));
         cmp("bar_number", 32'(want.bar_number), 32'(got.bar_number));
      endfunction
   endclass

   // ------------------------------------------------------------------
   // DUT hookup
   // ------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid, req_ready;
   logic        req_button_default_level, req_button_octave_level;
   logic [15:0] req_bar_interval_ms;
   logic        rsp_valid, rsp_ready;
   logic [2:0]  rsp_stage;
   logic [1:0]  rsp_motor_direction;
   logic [7:0]  rsp_motor_pwm;
   logic        rsp_light_main_one, rsp_light_main_two, rsp_light_main_three;
   logic        rsp_light_rhythm, rsp_bar_valid;
   logic [7:0]  rsp_bar_number;
   logic        csr_valid, csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   timed_stage_show_sequencer #(.TIMER_BITS(TIMER_BITS)) DUT (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_button_default_level (req_button_default_level),
      .req_button_octave_level  (req_button_octave_level),
      .req_bar_interval_ms      (req_bar_interval_ms),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_stage                (rsp_stage),
      .rsp_motor_direction      (rsp_motor_direction),
      .rsp_motor_pwm            (rsp_motor_pwm),
      .rsp_light_main_one       (rsp_light_main_one),
      .rsp_light_main_two       (rsp_light_main_two),
      .rsp_light_main_three     (rsp_light_main_three),
      .rsp_light_rhythm         (rsp_light_rhythm),
      .rsp_bar_valid            (rsp_bar_valid),
      .rsp_bar_number           (rsp_bar_number),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   show_tracker board;

   // idle knobs for the two sides (percent chance per item / cycle)
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   bit          long_hold_req = 1'b0;

   // button waveform state for the random part
   logic btn_def = 1'b0, btn_oct = 1'b0;
   int   run_def = 0, run_oct = 0;
   bit   gang = 1'b0;

   // ------------------------------------------------------------------
   // Receiver: random stall bursts, one long hold on request, counted here.
   // rsp_ready changes on the falling edge only.
   // ------------------------------------------------------------------
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            // long hold so the output and skid entries fill and req_ready drops
            long_hold_req = 1'b0;
            stall_left    = 79;
            rsp_ready     = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready = 1'b0;
         end else if (rsp_idle_pct != 0 && $urandom_range(99) < rsp_idle_pct) begin
            stall_left = $urandom_range(1, 16) - 1;
            rsp_ready  = 1'b0;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // result items are taken at the rising edge
   always @(posedge clock) begin
      tssq_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.stage           = rsp_stage;
         got.motor_direction = rsp_motor_direction;
         got.motor_pwm       = rsp_motor_pwm;
         got.lights          = {rsp_light_rhythm, rsp_light_main_three,
                                rsp_light_main_two, rsp_light_main_one};
         got.bar_valid       = rsp_bar_valid;
         got.bar_number      = rsp_bar_number;
         board.check_result(got);
      end
   end

   // ------------------------------------------------------------------
   // Drive tasks
   // ------------------------------------------------------------------

   // one tick item, with an optional random gap ahead of it
   task automatic send_tick(input logic dl, input logic ol, input logic [15:0] iv);
      if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      @(negedge clock);
      req_valid                = 1'b1;
      req_button_default_level = dl;
      req_button_octave_level  = ol;
      req_bar_interval_ms      = iv;
      do @(posedge clock); while (!req_ready);
      board.predict_tick(dl, ol, iv);
   endtask

   // stop offering and wait until every owed result is back
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // full register set; upper bits of the byte registers carry junk
   task automatic program_show(input logic [15:0] travel, input logic [15:0] settle,
                               input logic [7:0] deb, input logic [7:0] duty,
                               input logic [7:0] offs);
      logic [7:0] junk;
      junk = 8'($urandom_range(0, 255));
      drain();
      csr_write(CSR_CURTAIN_TRAVEL, travel);
      csr_write(CSR_SETTLE_WAIT, settle);
      csr_write(CSR_DEBOUNCE, {junk, deb});
      csr_write(CSR_MOTOR_DUTY, {~junk, duty});
      csr_write(CSR_OCTAVE_OFFSET, {junk ^ 8'h5a, offs});
   endtask

   // mostly holds longer than the debounce time, some short bounces
   function automatic int pick_run();
      if ($urandom_range(9) < 3) return $urandom_range(1, 3);
      return board.cfg.bounce_hold + $urandom_range(1, 25);
   endfunction

   // random button waveforms; gang mode ties both buttons for joint rises
   task automatic run_random(input int n_items);
      logic [15:0] iv;
      for (int k = 0; k < n_items; k++) begin
         if (run_def == 0) begin
            btn_def = ~btn_def;
            run_def = pick_run();
            if ($urandom_range(5) == 0) gang = ~gang;
         end
         run_def--;
         if (gang) begin
            btn_oct = btn_def;
            run_oct = run_def;
         end else begin
            if (run_oct <= 0) begin
               btn_oct = ~btn_oct;
               run_oct = pick_run();
            end
            run_oct--;
         end
         // short intervals keep play moving; odd long ones hit the upper bits
         if ($urandom_range(99) < 85) iv = 16'($urandom_range(0, 5));
         else iv = 16'($urandom_range(0, 16'hffff));
         send_tick(btn_def, btn_oct, iv);
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      board                    = new();
      reset                    = 1'b1;
      req_valid                = 1'b0;
      req_button_default_level = 1'b0;
      req_button_octave_level  = 1'b0;
      req_bar_interval_ms      = '0;
      csr_valid                = 1'b0;
      csr_index                = '0;
      csr_wdata                = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset config, interval extremes, button combos (too short to debounce)
      send_tick(1'b0, 1'b0, 16'h0000);
      send_tick(1'b1, 1'b0, 16'hffff);
      send_tick(1'b0, 1'b1, 16'h5555);
      send_tick(1'b1, 1'b1, 16'haaaa);
      send_tick(1'b0, 1'b0, 16'h0000);
      send_tick(1'b1, 1'b1, 16'h0000);

      // debounce zero, short curtain: both buttons rise together -> octave show,
      // zero interval gives a bar every tick
      program_show(16'd2, 16'd1, 8'd0, 8'd200, 8'd13);
      csr_write(CSR_UNUSED, 16'hffff);
      for (int k = 0; k < 19; k++) send_tick(1'b1, 1'b1, 16'h0000);

      // shortest nonzero timing, duty and offset at the top (bar numbers wrap)
      req_idle_pct = 30;
      rsp_idle_pct = 30;
      program_show(16'd1, 16'd1, 8'd0, 8'd255, 8'd255);
      run_random(150);

      // zero travel and wait end their stage on the next tick; duty zero
      req_idle_pct = 0;
      rsp_idle_pct = 20;
      program_show(16'd0, 16'd0, 8'd1, 8'd0, 8'd0);
      run_random(120);

      // random small settings, varying idle mix
      for (int seg = 0; seg < 3; seg++) begin
         req_idle_pct = (seg == 0) ? 0 : (seg == 1) ? 15 : 50;
         rsp_idle_pct = (seg == 2) ? 10 : 40;
         program_show(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                      8'($urandom_range(0, 12)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
         // sender runs flat out while the receiver holds off
         if (seg == 0) long_hold_req = 1'b1;
         run_random(100);
      end

      // longest debounce; the show outlasts the change counters' saturation
      req_idle_pct = 10;
      rsp_idle_pct = 10;
      program_show(16'd100, 16'd100, 8'd255, 8'($urandom_range(0, 255)), 8'd250);
      run_random(380);

      // duty / offset change in the middle of whatever stage is running
      drain();
      csr_write(CSR_MOTOR_DUTY, 16'($urandom_range(0, 16'hffff)));
      csr_write(CSR_OCTAVE_OFFSET, 16'($urandom_range(0, 16'hffff)));
      run_random(40);

      // last stretch: longest timing, no idling on either side
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      program_show(16'hffff, 16'hffff, 8'd3, 8'd77, 8'd128);
      run_random(100);

      drain();
      repeat (5) @(posedge clock);
      if (board.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
